@@ hw/rtl/mesh_color_mipmap_reduce_defines.svh @@
// Assertion macros for the mipmap reduce RTL
`ifndef MESH_COLOR_MIPMAP_REDUCE_DEFINES_SVH
`define MESH_COLOR_MIPMAP_REDUCE_DEFINES_SVH

// same-cycle implication
`define MCMR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mcmr assertion failed");

// next-cycle implication
`define MCMR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mcmr assertion failed");

`endif

@@ hw/rtl/mcmr_pkg.sv @@
// Types and constants for the mipmap reduce block
`default_nettype none
package mcmr_pkg;

    localparam int MAX_RES   = 1024;
    localparam int MAX_LEVEL = 10;
    localparam int CW        = 11;
    localparam int LW        = 4;
    localparam int PIXW      = 32;
    localparam int DEPTH     = MAX_RES + 1;
    localparam int SUMW      = 12;
    localparam int RCPW      = 13;
    localparam int RCP_SHIFT = 16;

    localparam logic [1:0] REG_RES_X = 2'd0;
    localparam logic [1:0] REG_RES_Y = 2'd1;
    localparam logic [1:0] REG_LEVEL = 2'd2;

    localparam logic [RCPW-1:0] RCP_16 = RCPW'(4096);
    localparam logic [RCPW-1:0] RCP_12 = RCPW'(5462);
    localparam logic [RCPW-1:0] RCP_9  = RCPW'(7282);

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } in_item_t;

    typedef struct packed {
        logic [CW-1:0] out_x;
        logic [CW-1:0] out_y;
        logic [7:0]    out_red;
        logic [7:0]    out_green;
        logic [7:0]    out_blue;
        logic [7:0]    out_alpha;
        logic          run_last;
        logic          frame_done;
    } out_item_t;

    typedef struct packed {
        logic [CW-1:0] span;
        logic [CW-1:0] tmax;
        logic          mul2;
    } axis_geom_t;

    typedef struct packed {
        logic [CW-1:0] t;
        logic          ofs;
        logic          lo_cut;
        logic          hi_cut;
    } centre_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SUM,
        ST_MUL,
        ST_SEND
    } state_t;

endpackage
`default_nettype wire

@@ hw/rtl/mcmr_ram.sv @@
// Generic single-port-write RAM with registered read
`default_nettype none
module mcmr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1025
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

@@ hw/rtl/mesh_color_mipmap_reduce.sv @@
// Top level: 3x3 tent filter mipmap reduction over two line-store RAMs
// out_valid rises once a taken request has passed through ST_LOAD, ST_SUM and ST_MUL.
// Each request passes ST_LOAD (window shift and line-store write-back), then yields no
//   result or up to 4, each through ST_SUM, ST_MUL and ST_SEND on a shared filter unit.
// One request at a time: in_ready is high only while nothing is in flight.
// Reset: counters and window clear, resolutions and level go to 1; line stores are not cleared.
`default_nettype none
module mesh_color_mipmap_reduce (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire mcmr_pkg::in_item_t  in_data,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output mcmr_pkg::out_item_t      out_data,
    input  wire logic                wr_en,
    input  wire logic [1:0]          wr_index,
    input  wire logic [10:0]         wr_data
);
    import mcmr_pkg::*;
    `include "mesh_color_mipmap_reduce_defines.svh"

    localparam int AW = $clog2(DEPTH);

    logic [CW-1:0] res_x_reg, res_y_reg;
    logic [LW-1:0] level_reg;
    logic [CW-1:0] col_reg, col_next, row_reg, row_next;
    state_t        state_reg, state_next;
    logic [PIXW-1:0] win_reg [9];
    logic [PIXW-1:0] pix_reg;
    logic [AW-1:0]   addr_reg;
    centre_t       cx_reg [2];
    centre_t       cy_reg [2];
    logic [1:0]    nx_reg, ny_reg;
    logic          i_reg, i_next, j_reg, j_next;
    logic          last_reg;
    logic [SUMW-1:0] sum_reg [4];
    logic [SUMW-1:0] sum_c [4];
    logic [RCPW-1:0] rcp_reg, rcp_c;
    out_item_t     out_reg;

    logic [PIXW-1:0] up_rd, mid_rd;
    axis_geom_t    gx, gy;
    centre_t       cxa [2];
    centre_t       cya [2];
    logic [1:0]    nxa, nya;
    logic          in_acc, out_acc, is_last_res;

    function automatic axis_geom_t geom(input logic [CW-1:0] res, input logic [3:0] sh);
        axis_geom_t    g;
        logic [CW-1:0] r;
        logic [CW-1:0] p;
        r = res;
        if (res == '0)
        begin
            r = CW'(1);
        end
        else if (res > CW'(MAX_RES))
        begin
            r = CW'(MAX_RES);
        end
        p = CW'(1) << sh;
        g.mul2 = r > p;
        g.span = (r > p) ? (r >> sh) : CW'(1);
        g.tmax = ((CW'(2) << sh) < r) ? (r >> (sh + 4'd1)) : CW'(1);
        return g;
    endfunction

    // compacted list of centres whose window completes at position e
    function automatic logic [1:0] centres(input axis_geom_t g, input logic [CW-1:0] e,
                                           output centre_t c0, output centre_t c1);
        logic          a, b;
        logic [CW-1:0] em1, ta, tb;
        centre_t       ca, cb;
        em1 = e - CW'(1);
        ta  = g.mul2 ? (em1 >> 1) : em1;
        tb  = g.mul2 ? ((g.span + CW'(1)) >> 1) : g.span;
        a   = (e != '0) && (em1 < g.span) && (!g.mul2 || !em1[0]) && (ta <= g.tmax);
        b   = (e == g.span) && (tb <= g.tmax);
        ca  = '{t: ta, ofs: 1'b1, lo_cut: (e == CW'(1)), hi_cut: 1'b0};
        cb  = '{t: tb, ofs: 1'b0, lo_cut: 1'b0, hi_cut: 1'b1};
        c0  = a ? ca : cb;
        c1  = cb;
        return {1'b0, a} + {1'b0, b};
    endfunction

    always_comb
    begin
        logic [3:0] lv;
        lv = level_reg;
        if (lv == '0)
        begin
            lv = 4'd1;
        end
        else if (lv > LW'(MAX_LEVEL))
        begin
            lv = LW'(MAX_LEVEL);
        end
        gx  = geom(res_x_reg, lv - 4'd1);
        gy  = geom(res_y_reg, lv - 4'd1);
        nxa = centres(gx, col_reg, cxa[0], cxa[1]);
        nya = centres(gy, row_reg, cya[0], cya[1]);
    end

    assign in_ready = (state_reg == ST_IDLE);
    assign in_acc   = in_valid && in_ready;
    assign out_valid = (state_reg == ST_SEND);
    assign out_acc  = out_valid && out_ready;
    assign out_data = out_reg;
    assign is_last_res = (i_reg == nx_reg[1]) && (j_reg == ny_reg[1]);

    mcmr_ram #(.WIDTH(PIXW), .DEPTH(DEPTH)) u_upper (
        .clk   (clk),
        .we    (state_reg == ST_LOAD),
        .waddr (addr_reg),
        .wdata (mid_rd),
        .raddr (col_reg[AW-1:0]),
        .rdata (up_rd)
    );

    mcmr_ram #(.WIDTH(PIXW), .DEPTH(DEPTH)) u_middle (
        .clk   (clk),
        .we    (state_reg == ST_LOAD),
        .waddr (addr_reg),
        .wdata (pix_reg),
        .raddr (col_reg[AW-1:0]),
        .rdata (mid_rd)
    );

    // weighted 3x3 sums for the selected centre pair
    always_comb
    begin
        centre_t cx, cy;
        int      r, c, w, wt;
        int      acc [4];
        cx = cx_reg[i_reg];
        cy = cy_reg[j_reg];
        wt = 0;
        for (int k = 0; k < 4; k++)
        begin
            acc[k] = 0;
        end
        for (int dy = 0; dy < 3; dy++)
        begin
            for (int dx = 0; dx < 3; dx++)
            begin
                r = 1 - int'(cy.ofs) + dy;
                c = 1 - int'(cx.ofs) + dx;
                w = (dx == 1 && dy == 1) ? 4 : ((dx == 1 || dy == 1) ? 2 : 1);
                if (!(dy == 0 && cy.lo_cut) && !(dy == 2 && cy.hi_cut) &&
                    !(dx == 0 && cx.lo_cut) && !(dx == 2 && cx.hi_cut) &&
                    r <= 2 && c <= 2)
                begin
                    for (int k = 0; k < 4; k++)
                    begin
                        acc[k] = acc[k] + w * int'(win_reg[r * 3 + c][8 * k +: 8]);
                    end
                    wt = wt + w;
                end
            end
        end
        for (int k = 0; k < 4; k++)
        begin
            sum_c[k] = acc[k][SUMW-1:0];
        end
        case (wt)
            12:      rcp_c = RCP_12;
            9:       rcp_c = RCP_9;
            default: rcp_c = RCP_16;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = ST_LOAD;
                    if (col_reg >= gx.span)
                    begin
                        col_next = '0;
                        row_next = (row_reg >= gy.span) ? '0 : row_reg + CW'(1);
                    end
                    else
                    begin
                        col_next = col_reg + CW'(1);
                    end
                end
            end
            ST_LOAD:
            begin
                i_next = 1'b0;
                j_next = 1'b0;
                state_next = (nx_reg == '0 || ny_reg == '0) ? ST_IDLE : ST_SUM;
            end
            ST_SUM:
            begin
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                state_next = ST_SEND;
            end
            ST_SEND:
            begin
                if (out_acc)
                begin
                    if (is_last_res)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_SUM;
                        if (i_reg == nx_reg[1])
                        begin
                            i_next = 1'b0;
                            j_next = 1'b1;
                        end
                        else
                        begin
                            i_next = 1'b1;
                        end
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
        if (wr_en && (wr_index == REG_RES_X || wr_index == REG_RES_Y ||
                      wr_index == REG_LEVEL))
        begin
            col_next = '0;
            row_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            col_reg   <= '0;
            row_reg   <= '0;
            res_x_reg <= CW'(1);
            res_y_reg <= CW'(1);
            level_reg <= LW'(1);
            i_reg     <= 1'b0;
            j_reg     <= 1'b0;
            for (int k = 0; k < 9; k++)
            begin
                win_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            if (wr_en)
            begin
                unique case (wr_index)
                    REG_RES_X: res_x_reg <= wr_data;
                    REG_RES_Y: res_y_reg <= wr_data;
                    REG_LEVEL: level_reg <= wr_data[LW-1:0];
                    default:   ;
                endcase
            end
            if (state_reg == ST_LOAD)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    win_reg[k * 3 + 0] <= win_reg[k * 3 + 1];
                    win_reg[k * 3 + 1] <= win_reg[k * 3 + 2];
                end
                win_reg[2] <= up_rd;
                win_reg[5] <= mid_rd;
                win_reg[8] <= pix_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            pix_reg  <= {in_data.alpha, in_data.blue, in_data.green, in_data.red};
            addr_reg <= col_reg[AW-1:0];
            cx_reg   <= cxa;
            cy_reg   <= cya;
            nx_reg   <= nxa;
            ny_reg   <= nya;
            last_reg <= (col_reg == gx.span) && (row_reg == gy.span);
        end
        if (state_reg == ST_SUM)
        begin
            sum_reg <= sum_c;
            rcp_reg <= rcp_c;
        end
        if (state_reg == ST_MUL)
        begin
            logic [SUMW+RCPW-1:0] prod [4];
            for (int k = 0; k < 4; k++)
            begin
                prod[k] = (SUMW + RCPW)'(sum_reg[k]) * (SUMW + RCPW)'(rcp_reg);
            end
            out_reg.out_x      <= cx_reg[i_reg].t;
            out_reg.out_y      <= cy_reg[j_reg].t;
            out_reg.out_red    <= prod[0][RCP_SHIFT +: 8];
            out_reg.out_green  <= prod[1][RCP_SHIFT +: 8];
            out_reg.out_blue   <= prod[2][RCP_SHIFT +: 8];
            out_reg.out_alpha  <= prod[3][RCP_SHIFT +: 8];
            out_reg.run_last   <= is_last_res;
            out_reg.frame_done <= is_last_res && last_reg;
        end
    end

    `MCMR_ASSERT_NOW(a_one_in_flight, clk, rst_n, in_ready, !out_valid)
    `MCMR_ASSERT_NEXT(a_accept_loads, clk, rst_n, in_acc, state_reg == ST_LOAD)
    `MCMR_ASSERT_NOW(a_index_range, clk, rst_n, state_reg == ST_SUM,
        ({1'b0, i_reg} < nx_reg) && ({1'b0, j_reg} < ny_reg))
    `MCMR_ASSERT_NOW(a_frame_wrap, clk, rst_n, out_valid && out_data.frame_done,
        col_reg == '0 && row_reg == '0)

endmodule
`default_nettype wire

@@ bench/mesh_color_mipmap_reduce_tb.sv @@
// Testbench for mesh_color_mipmap_reduce: scoreboard against a tent-filter mipmap predictor
`default_nettype none
module mesh_color_mipmap_reduce_tb;
    import mcmr_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    in_item_t in_data;
    logic out_valid;
    logic out_ready;
    out_item_t out_data;
    logic wr_en;
    logic [1:0] wr_index;
    logic [10:0] wr_data;

    mesh_color_mipmap_reduce u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // predictor state
    logic [31:0] upper_line [0:MAX_RES];
    logic [31:0] middle_line [0:MAX_RES];
    logic [31:0] win [0:8];
    int unsigned col_pos;
    int unsigned row_pos;
    int unsigned res_x_reg;
    int unsigned res_y_reg;
    int unsigned level_reg;

    out_item_t pixel_queue [$];
    int fail_count;
    int request_count;
    int pixel_count;
    int frame_count;
    int send_idle_pct;
    int recv_idle_pct;
    bit recv_hold;
    int idle_cycles;

    function automatic void axis_geom(input int unsigned res_reg, output int unsigned span,
                                      output int unsigned tmax, output int unsigned mul);
        int unsigned r;
        int unsigned lv;
        int unsigned p;
        int unsigned sp;
        int unsigned s2;
        r = (res_reg == 0) ? 1 : ((res_reg > MAX_RES) ? MAX_RES : res_reg);
        lv = (level_reg < 1) ? 1 : ((level_reg > MAX_LEVEL) ? MAX_LEVEL : level_reg);
        p = 1 << (lv - 1);
        sp = (p < r) ? p : r;
        s2 = (2 * p < r) ? 2 * p : r;
        span = r / sp;
        tmax = r / s2;
        mul = (r > p) ? 2 : 1;
    endfunction

    function automatic int centres(input int unsigned span, input int unsigned tmax,
                                   input int unsigned mul, input int unsigned e,
                                   output int unsigned tg [2], output int unsigned sc [2]);
        int n;
        int unsigned t;
        n = 0;
        if (e >= 1 && e - 1 < span && ((e - 1) % mul) == 0)
        begin
            t = (e - 1) / mul;
            if (t <= tmax)
            begin
                tg[n] = t;
                sc[n] = e - 1;
                n++;
            end
        end
        if (e == span)
        begin
            t = (span + mul - 1) / mul;
            if (t <= tmax)
            begin
                tg[n] = t;
                sc[n] = span;
                n++;
            end
        end
        return n;
    endfunction

    function automatic logic [31:0] tent_filter(input int unsigned cx, input int unsigned dxo,
                                                input int unsigned sx, input int unsigned cy,
                                                input int unsigned dyo, input int unsigned sy);
        int unsigned acc [4];
        int unsigned wt;
        int unsigned w;
        int r;
        int c;
        logic [31:0] res;
        acc = '{0, 0, 0, 0};
        wt = 0;
        for (int dy = -1; dy <= 1; dy++)
        begin
            if ((dy < 0 && cy == 0) || (dy > 0 && cy >= sy))
                continue;
            for (int dx = -1; dx <= 1; dx++)
            begin
                if ((dx < 0 && cx == 0) || (dx > 0 && cx >= sx))
                    continue;
                r = 2 - int'(dyo) + dy;
                c = 2 - int'(dxo) + dx;
                if (r < 0 || r > 2 || c < 0 || c > 2)
                    continue;
                w = (dx == 0 && dy == 0) ? 4 : ((dx == 0 || dy == 0) ? 2 : 1);
                for (int k = 0; k < 4; k++)
                    acc[k] += w * win[r * 3 + c][8 * k +: 8];
                wt += w;
            end
        end
        for (int k = 0; k < 4; k++)
            res[8 * k +: 8] = 8'(acc[k] / wt);
        return res;
    endfunction

    function automatic void predict_pixels(input in_item_t item);
        int unsigned sx, tx_max, mx, sy, ty_max, my;
        int unsigned txs [2], sxs [2], tys [2], sys [2];
        int unsigned ci;
        int nx, ny;
        logic [31:0] pix;
        logic [31:0] ch;
        out_item_t o;
        bit last_sample;
        axis_geom(res_x_reg, sx, tx_max, mx);
        axis_geom(res_y_reg, sy, ty_max, my);
        pix = {item.alpha, item.blue, item.green, item.red};
        ci = (col_pos <= MAX_RES) ? col_pos : MAX_RES;
        for (int i = 0; i < 3; i++)
        begin
            win[i * 3] = win[i * 3 + 1];
            win[i * 3 + 1] = win[i * 3 + 2];
        end
        win[2] = upper_line[ci];
        win[5] = middle_line[ci];
        win[8] = pix;
        upper_line[ci] = middle_line[ci];
        middle_line[ci] = pix;
        nx = centres(sx, tx_max, mx, col_pos, txs, sxs);
        ny = centres(sy, ty_max, my, row_pos, tys, sys);
        last_sample = (col_pos == sx && row_pos == sy);
        for (int j = 0; j < ny; j++)
            for (int i = 0; i < nx; i++)
            begin
                ch = tent_filter(sxs[i], col_pos - sxs[i], sx, sys[j], row_pos - sys[j], sy);
                o.out_x = CW'(txs[i]);
                o.out_y = CW'(tys[j]);
                o.out_red = ch[7:0];
                o.out_green = ch[15:8];
                o.out_blue = ch[23:16];
                o.out_alpha = ch[31:24];
                o.run_last = (j == ny - 1 && i == nx - 1);
                o.frame_done = o.run_last && last_sample;
                pixel_queue.push_back(o);
            end
        col_pos++;
        if (col_pos > sx)
        begin
            col_pos = 0;
            row_pos++;
            if (row_pos > sy)
                row_pos = 0;
        end
    endfunction

    function automatic int unsigned frame_samples();
        int unsigned sx, tx_max, mx, sy, ty_max, my;
        axis_geom(res_x_reg, sx, tx_max, mx);
        axis_geom(res_y_reg, sy, ty_max, my);
        return (sx + 1) * (sy + 1);
    endfunction

    // result checker and receiver stalls
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                pixel_count++;
                if (pixel_queue.size() == 0)
                begin
                    $display("%0t: unexpected pixel, got %p", $time, out_data);
                    fail_count++;
                end
                else
                begin
                    if (pixel_queue[0] !== out_data)
                    begin
                        $display("%0t: pixel mismatch, expected %p, got %p",
                                 $time, pixel_queue[0], out_data);
                        fail_count++;
                    end
                    if (pixel_queue[0].frame_done)
                        frame_count++;
                    void'(pixel_queue.pop_front());
                end
            end
            out_ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // watchdog on cycles with no handshake
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || wr_en)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG_LIMIT)
        begin
            $display("watchdog expired");
            $display("end of test: mismatches");
            $finish;
        end
    end

    // valid stays up across back-to-back requests; callers drop it when done
    task automatic send_sample(input in_item_t item);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= item;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_pixels(item);
        request_count++;
    endtask

    task automatic drain();
        while (pixel_queue.size() != 0)
            @(posedge clk);
        repeat (12)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input int unsigned val);
        wr_en <= 1'b1;
        wr_index <= idx;
        wr_data <= 11'(val);
        @(posedge clk);
        case (idx)
            REG_RES_X: res_x_reg = val & 11'h7ff;
            REG_RES_Y: res_y_reg = val & 11'h7ff;
            default: level_reg = val & 4'hf;
        endcase
        col_pos = 0;
        row_pos = 0;
    endtask

    task automatic set_frame(input int unsigned rx, input int unsigned ry,
                             input int unsigned lv);
        in_valid <= 1'b0;
        drain();
        write_reg(REG_RES_X, rx);
        write_reg(REG_RES_Y, ry);
        write_reg(REG_LEVEL, lv);
        wr_en <= 1'b0;
    endtask

    function automatic in_item_t rand_sample();
        return in_item_t'($urandom);
    endfunction

    task automatic send_frame(input int kind);
        int unsigned n;
        in_item_t s;
        n = frame_samples();
        for (int i = 0; i < n; i++)
        begin
            case (kind)
                0: s = '0;
                1: s = '1;
                2: s = (i % 2) ? '1 : '0;
                default: s = rand_sample();
            endcase
            send_sample(s);
        end
    endtask

    task automatic test_directed();
        set_frame(1, 1, 1);
        send_frame(0);
        send_frame(1);
        set_frame(4, 2, 2);
        send_frame(2);
        set_frame(3, 3, 1);
        send_frame(3);
        set_frame(0, 2047, 15);
        send_frame(3);
    endtask

    task automatic test_random_frames(input int budget);
        int unsigned lv;
        int unsigned rx;
        int unsigned ry;
        int sent;
        sent = 0;
        while (sent < budget)
        begin
            lv = $urandom_range(1, 10);
            case ($urandom_range(3))
                0: begin rx = $urandom_range(1, 4); ry = $urandom_range(1, 4); end
                1: begin rx = 1 << (lv - 1); ry = $urandom_range(1, 6) << (lv - 1); end
                2: begin rx = $urandom_range(1, 12) << (lv - 1); ry = $urandom_range(1, 3); end
                default: begin rx = $urandom_range(1, 1024); ry = rx; lv = 10; end
            endcase
            set_frame(rx, ry, lv);
            if (frame_samples() > 120)
                continue;
            if ($urandom_range(5) == 0)
            begin
                for (int i = 0; i < $urandom_range(1, 5); i++)
                    send_sample(rand_sample());
                sent += 3;
            end
            else
            begin
                sent += frame_samples();
                send_frame(3);
            end
        end
    endtask

    task automatic test_backpressure();
        set_frame(8, 8, 1);
        fork
            begin
                recv_hold = 1'b1;
                repeat (200)
                    @(posedge clk);
                recv_hold = 1'b0;
            end
            begin
                send_frame(3);
                in_valid <= 1'b0;
            end
        join
        drain();
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b0;
        wr_en = 1'b0;
        wr_index = REG_RES_X;
        wr_data = '0;
        fail_count = 0;
        request_count = 0;
        pixel_count = 0;
        frame_count = 0;
        recv_hold = 1'b0;
        idle_cycles = 0;
        col_pos = 0;
        row_pos = 0;
        res_x_reg = 1;
        res_y_reg = 1;
        level_reg = 1;
        for (int i = 0; i < 9; i++)
            win[i] = '0;
        send_idle_pct = 18;
        recv_idle_pct = 55;
        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_frames(50);
        send_idle_pct = 55;
        recv_idle_pct = 18;
        test_random_frames(50);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_frames(50);
        test_backpressure();
        drain();
        $display("covered %0d requests, %0d pixels, %0d full frames", request_count,
                 pixel_count, frame_count);
        $display("levels 1..10 incl. saturated, resolutions 0..2047, stalls and pauses");
        if (fail_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule
`default_nettype wire

@@ files.f @@
+incdir+hw/rtl
hw/rtl/mcmr_pkg.sv
hw/rtl/mcmr_ram.sv
hw/rtl/mesh_color_mipmap_reduce.sv
bench/mesh_color_mipmap_reduce_tb.sv
